// File: design/stable_priority_message_queue_unit_macros.svh
// Assertion macros for the stable priority message queue unit.
`ifndef STABLE_PRIORITY_MESSAGE_QUEUE_UNIT_MACROS_SVH
`define STABLE_PRIORITY_MESSAGE_QUEUE_UNIT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define SPMQ_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a condition implies an expression in the same cycle.
`define SPMQ_ASSERT_SAME(label, trig, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (expr)) \
		else $error(msg);

// Check that a condition implies an expression in the next cycle.
`define SPMQ_ASSERT_NEXT(label, trig, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) \
		else $error(msg);

`endif

// File: design/spmq_pkg.sv
// Shared constants and types of the stable priority message queue.
package spmq_pkg;

	localparam int OP_W  = 2;
	localparam int LEN_W = 16;
	localparam int CFG_W = 5;
	localparam int ST_W  = 2;

	localparam logic [OP_W-1:0] OP_SEND  = 2'd0;
	localparam logic [OP_W-1:0] OP_RECV  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [CFG_W-1:0] MAX_COUNT_RESET = 5'd16;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

endpackage

// File: design/spmq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spmq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/spmq_cmp.sv
// Shared unsigned compare unit: a >= b and the lesser of the two.
module spmq_cmp #(
	parameter int W = 16
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         a_ge_b,
	output logic [W-1:0] min_ab
);

	assign a_ge_b = (a >= b);
	assign min_ab = a_ge_b ? b : a;

endmodule

// File: design/stable_priority_message_queue_unit.sv
// Top level of the stable priority message queue unit.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_data (max_count)
//  in      | in        | in_valid/in_ready    | operation, send_*, receive_capacity
//  out     | out       | out_valid/out_ready  | status, recv_*, queue_count
//
// A refused send, a send into an empty queue, a receive on an empty queue and a clear are done
// in S_EXEC; any other send walks S_SCAN past the entries it moves and lands from S_SCAN or
// S_PUT, and a receive ends in S_POP. The single read and write port of the entry RAM sets
// the pace of the insertion walk: one entry is compared and moved per cycle.
// Reset (arst_n low) empties the queue and sets max_count to 16; the RAM is not cleared.
// A result waits in the output register while out_ready is low; the next beat is accepted
// meanwhile, and its result holds in the sequencer until the output register frees up.
`include "stable_priority_message_queue_unit_macros.svh"

module stable_priority_message_queue_unit #(
	parameter int DEPTH = 16,
	parameter int PRIO_WIDTH = 8,
	parameter int PAYLOAD_WIDTH = 32,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration write channel
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [spmq_pkg::CFG_W-1:0] cfg_data,
	// item channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [spmq_pkg::OP_W-1:0]  operation,
	input  logic [PRIO_WIDTH-1:0]      send_priority,
	input  logic [PAYLOAD_WIDTH-1:0]   send_payload,
	input  logic [spmq_pkg::LEN_W-1:0] send_length,
	input  logic [spmq_pkg::LEN_W-1:0] receive_capacity,
	// result channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [spmq_pkg::ST_W-1:0]  status,
	output logic [PAYLOAD_WIDTH-1:0]   recv_payload,
	output logic [PRIO_WIDTH-1:0]      recv_priority,
	output logic [spmq_pkg::LEN_W-1:0] recv_length,
	output logic [CNT_W-1:0]           queue_count
);

	import spmq_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int E_W   = PRIO_WIDTH + PAYLOAD_WIDTH + LEN_W;
	localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int CMP_W = (PRIO_WIDTH > LEN_W) ? PRIO_WIDTH : LEN_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_PUT,
		S_POP
	} state_t;

	// Map a logical position (0 is the head) onto a RAM slot of the circular buffer.
	function automatic logic [PTR_W-1:0] slot_addr(input logic [PTR_W-1:0] base,
	                                              input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(DEPTH)) begin
			sum = sum - (CNT_W+1)'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	// sequencer and item registers
	state_t                 state_q, state_d;
	logic [OP_W-1:0]        op_q;
	logic [PRIO_WIDTH-1:0]  prio_q;
	logic [PAYLOAD_WIDTH-1:0] pay_q;
	logic [LEN_W-1:0]       len_q;
	logic [LEN_W-1:0]       cap_q;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic [PTR_W-1:0]       head_q, head_d;
	logic [CNT_W-1:0]       k_q, k_d;
	logic [CFG_W-1:0]       max_q;

	// result register
	logic                   out_valid_q;
	status_t                status_q;
	logic [PAYLOAD_WIDTH-1:0] rpay_q;
	logic [PRIO_WIDTH-1:0]  rprio_q;
	logic [LEN_W-1:0]       rlen_q;
	logic [CNT_W-1:0]       rcnt_q;

	// result of the current step
	logic                   res_load;
	status_t                res_status;
	logic [PAYLOAD_WIDTH-1:0] res_pay;
	logic [PRIO_WIDTH-1:0]  res_prio;
	logic [LEN_W-1:0]       res_len;

	// entry RAM
	logic                   ram_we, ram_re;
	logic [CNT_W-1:0]       wr_off, rd_off;
	logic [PTR_W-1:0]       ram_waddr, ram_raddr;
	logic [E_W-1:0]         ram_wdata, ram_rdata;
	logic [E_W-1:0]         new_entry;
	logic [PRIO_WIDTH-1:0]  rd_prio;
	logic [PAYLOAD_WIDTH-1:0] rd_pay;
	logic [LEN_W-1:0]       rd_len;

	// shared compare unit
	logic [CMP_W-1:0]       cmp_a, cmp_b, cmp_min;
	logic                   cmp_ge;

	logic                   out_free;
	logic [LIM_W-1:0]       limit;
	logic                   full;
	logic                   send_go;
	logic [CNT_W-1:0]       k_dec;

	// terms watched by the checks at the end
	logic                   send_ok;
	logic                   scan_k_ok;
	logic [CNT_W-1:0]       cnt_inc;

	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);

	// Saturate the configured limit at the depth of the RAM.
	assign limit   = (LIM_W'(max_q) < LIM_W'(DEPTH)) ? LIM_W'(max_q) : LIM_W'(DEPTH);
	assign full    = (LIM_W'(cnt_q) >= limit);
	assign send_go = (len_q != '0) && !full;
	assign k_dec   = k_q - 1'b1;

	assign new_entry = {prio_q, pay_q, len_q};
	assign rd_prio   = ram_rdata[E_W-1 -: PRIO_WIDTH];
	assign rd_pay    = ram_rdata[LEN_W +: PAYLOAD_WIDTH];
	assign rd_len    = ram_rdata[LEN_W-1:0];

	// Compare priorities during the insertion walk, capacity against length on a pop.
	always_comb begin
		case (state_q)
			S_POP: begin
				cmp_a = CMP_W'(cap_q);
				cmp_b = CMP_W'(rd_len);
			end
			default: begin
				cmp_a = CMP_W'(rd_prio);
				cmp_b = CMP_W'(prio_q);
			end
		endcase
	end

	spmq_cmp #(
		.W(CMP_W)
	) u_cmp (
		.a     (cmp_a),
		.b     (cmp_b),
		.a_ge_b(cmp_ge),
		.min_ab(cmp_min)
	);

	// RAM port control: walk from the tail toward the head, shifting lower entries back.
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		wr_off    = k_q;
		rd_off    = '0;
		ram_wdata = new_entry;
		case (state_q)
			S_EXEC: begin
				if (op_q == OP_SEND && send_go) begin
					if (cnt_q == '0) begin
						ram_we = out_free;
						wr_off = '0;
					end else begin
						ram_re = 1'b1;
						rd_off = cnt_q - 1'b1;
					end
				end else if (op_q == OP_RECV && cnt_q != '0) begin
					ram_re = 1'b1;
					rd_off = '0;
				end
			end
			S_SCAN: begin
				if (cmp_ge) begin
					// entry ahead is not lower: land here
					ram_we = out_free;
				end else begin
					// move the lower entry one place back, fetch the next one up
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
					if (k_q > CNT_W'(1)) begin
						ram_re = 1'b1;
						rd_off = k_q - CNT_W'(2);
					end
				end
			end
			S_PUT: begin
				ram_we = out_free;
				wr_off = '0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign ram_waddr = slot_addr(head_q, wr_off);
	assign ram_raddr = slot_addr(head_q, rd_off);

	spmq_ram #(
		.WIDTH(E_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Next state and result of the current step.
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		head_d     = head_q;
		k_d        = k_q;
		res_load   = 1'b0;
		res_status = ST_OK;
		res_pay    = '0;
		res_prio   = '0;
		res_len    = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (op_q)
					OP_SEND: begin
						if (len_q == '0) begin
							res_status = ST_INVALID;
							res_load   = out_free;
						end else if (full) begin
							res_status = ST_FULL;
							res_load   = out_free;
						end else if (cnt_q == '0) begin
							res_load = out_free;
							if (out_free) begin
								cnt_d = cnt_q + 1'b1;
							end
						end else begin
							state_d = S_SCAN;
							k_d     = cnt_q;
						end
					end
					OP_RECV: begin
						if (cnt_q == '0) begin
							res_status = ST_EMPTY;
							res_load   = out_free;
						end else begin
							state_d = S_POP;
						end
					end
					OP_CLEAR: begin
						res_load = out_free;
						if (out_free) begin
							cnt_d = '0;
						end
					end
					default: begin
						res_load = out_free;
					end
				endcase
				if (res_load) begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (cmp_ge) begin
					if (out_free) begin
						res_load = 1'b1;
						cnt_d    = cnt_q + 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					k_d = k_dec;
					if (k_q == CNT_W'(1)) begin
						state_d = S_PUT;
					end
				end
			end
			S_PUT: begin
				if (out_free) begin
					res_load = 1'b1;
					cnt_d    = cnt_q + 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_POP: begin
				if (out_free) begin
					res_load = 1'b1;
					res_pay  = rd_pay;
					res_prio = rd_prio;
					res_len  = cmp_min[LEN_W-1:0];
					cnt_d    = cnt_q - 1'b1;
					head_d   = slot_addr(head_q, CNT_W'(1));
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state, configuration and the valid bit of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			head_q      <= '0;
			k_q         <= '0;
			max_q       <= MAX_COUNT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			head_q  <= head_d;
			k_q     <= k_d;
			if (cfg_valid) begin
				max_q <= cfg_data;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item and result payload: hold until the next beat.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= operation;
			prio_q <= send_priority;
			pay_q  <= send_payload;
			len_q  <= send_length;
			cap_q  <= receive_capacity;
		end
		if (res_load) begin
			status_q <= res_status;
			rpay_q   <= res_pay;
			rprio_q  <= res_prio;
			rlen_q   <= res_len;
			rcnt_q   <= cnt_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign recv_payload  = rpay_q;
	assign recv_priority = rprio_q;
	assign recv_length   = rlen_q;
	assign queue_count   = rcnt_q;

	assign send_ok   = res_load && op_q == OP_SEND && res_status == ST_OK;
	assign scan_k_ok = k_q != '0 && k_q <= cnt_q;
	assign cnt_inc   = cnt_q + 1'b1;

	`SPMQ_ASSERT_ALWAYS(a_count_in_range, cnt_q <= CNT_W'(DEPTH), "held count exceeds depth")
	`SPMQ_ASSERT_SAME(a_scan_index, state_q == S_SCAN, scan_k_ok, "walk index out of range")
	`SPMQ_ASSERT_NEXT(a_send_grows, send_ok, cnt_q == $past(cnt_inc), "send did not grow queue")

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the stable priority message queue unit.
`timescale 1ns / 100ps

module tb;
	import spmq_pkg::*;

	localparam int DEPTH         = 16;
	localparam int PRIO_WIDTH    = 8;
	localparam int PAYLOAD_WIDTH = 32;
	localparam int CNT_W         = $clog2(DEPTH + 1);

	// Operation code that the block must treat as a no-op.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 200;
	localparam int SQUEEZE_PHASE = 3;    // phase that opens with the long output stall
	localparam int LONG_HOLD     = 300;  // cycles the result side refuses beats
	localparam int TAIL_LEN      = 150;  // last items run with no idling on either side
	localparam int DRAIN_CYCLES  = 40;
	localparam int CYCLE_LIMIT   = 400000;

	typedef enum logic [1:0] {K_OP, K_LIMIT, K_SQUEEZE} step_kind_t;

	// One entry of the stimulus list: a beat, a max_count write or a stall request.
	typedef struct {
		step_kind_t                kind;
		logic [OP_W-1:0]           op;
		logic [PRIO_WIDTH-1:0]     prio;
		logic [PAYLOAD_WIDTH-1:0]  payload;
		logic [LEN_W-1:0]          len;
		logic [LEN_W-1:0]          cap;
		logic [CFG_W-1:0]          limit;
	} queue_op_t;

	// A message held in the shadow queue.
	typedef struct {
		logic [PRIO_WIDTH-1:0]     prio;
		logic [PAYLOAD_WIDTH-1:0]  payload;
		logic [LEN_W-1:0]          len;
	} msg_t;

	// Result beat as the block must return it.
	typedef struct {
		status_t                   status;
		logic [PAYLOAD_WIDTH-1:0]  payload;
		logic [PRIO_WIDTH-1:0]     prio;
		logic [LEN_W-1:0]          len;
		logic [CNT_W-1:0]          count;
	} reply_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [OP_W-1:0]          operation = '0;
	logic [PRIO_WIDTH-1:0]    send_priority = '0;
	logic [PAYLOAD_WIDTH-1:0] send_payload = '0;
	logic [LEN_W-1:0]         send_length = '0;
	logic [LEN_W-1:0]         receive_capacity = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [ST_W-1:0]          status;
	logic [PAYLOAD_WIDTH-1:0] recv_payload;
	logic [PRIO_WIDTH-1:0]    recv_priority;
	logic [LEN_W-1:0]         recv_length;
	logic [CNT_W-1:0]         queue_count;

	// Stimulus still to be offered, shadow of the held messages, results still owed.
	queue_op_t ops_todo[$];
	msg_t      shadow_msgs[$];
	reply_t    replies_due[$];

	logic [CFG_W-1:0] max_held_cfg = MAX_COUNT_RESET;
	logic [CFG_W-1:0] phase_limits [PHASES] = '{5'd31, 5'd1, 5'd0, 5'd16, 5'd2, 5'd17, 5'd5,
		5'd16};

	int errors       = 0;
	int cycle_count  = 0;
	int idle_left    = 0;
	int idle_pct     = 20;
	int stall_left   = 0;
	int hold_left    = 0;
	int squeeze_asks = 0;
	int squeeze_seen = 0;
	int limit_writes = 0;
	int ops_taken    = 0;
	int replies_seen = 0;
	int deepest      = 0;
	int op_hits [4]     = '{0, 0, 0, 0};
	int status_hits [4] = '{0, 0, 0, 0};

	stable_priority_message_queue_unit #(
		.DEPTH(DEPTH),
		.PRIO_WIDTH(PRIO_WIDTH),
		.PAYLOAD_WIDTH(PAYLOAD_WIDTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.send_priority(send_priority),
		.send_payload(send_payload),
		.send_length(send_length),
		.receive_capacity(receive_capacity),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.recv_payload(recv_payload),
		.recv_priority(recv_priority),
		.recv_length(recv_length),
		.queue_count(queue_count)
	);

	always #5 clk = ~clk;

	// Apply one accepted beat to the shadow queue and return the result it owes.
	// Order: highest priority first, equal priorities in send order.
	function automatic reply_t shadow_apply(logic [OP_W-1:0] op, logic [PRIO_WIDTH-1:0] prio,
			logic [PAYLOAD_WIDTH-1:0] payload, logic [LEN_W-1:0] len, logic [LEN_W-1:0] cap);
		reply_t r;
		msg_t   m;
		int     room;
		int     pos;
		r.status  = ST_OK;
		r.payload = '0;
		r.prio    = '0;
		r.len     = '0;
		// max_count above DEPTH saturates at DEPTH; zero refuses every send
		room = (max_held_cfg < DEPTH) ? max_held_cfg : DEPTH;
		case (op)
		OP_SEND: begin
			// a zero length is refused before fullness is looked at
			if (len == '0) begin
				r.status = ST_INVALID;
			end else if (shadow_msgs.size() >= room) begin
				r.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < shadow_msgs.size() && shadow_msgs[pos].prio >= prio)
					pos++;
				m.prio    = prio;
				m.payload = payload;
				m.len     = len;
				shadow_msgs.insert(pos, m);
			end
		end
		OP_RECV: begin
			if (shadow_msgs.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				m         = shadow_msgs.pop_front();
				r.payload = m.payload;
				r.prio    = m.prio;
				r.len     = (cap < m.len) ? cap : m.len;
			end
		end
		OP_CLEAR: begin
			shadow_msgs.delete();
		end
		default: begin
			// unused code: nothing moves, plain success
		end
		endcase
		r.count = CNT_W'(shadow_msgs.size());
		return r;
	endfunction

	function automatic void add_op(logic [OP_W-1:0] op, logic [PRIO_WIDTH-1:0] prio,
			logic [PAYLOAD_WIDTH-1:0] payload, logic [LEN_W-1:0] len, logic [LEN_W-1:0] cap);
		queue_op_t s;
		s.kind    = K_OP;
		s.op      = op;
		s.prio    = prio;
		s.payload = payload;
		s.len     = len;
		s.cap     = cap;
		s.limit   = '0;
		ops_todo.push_back(s);
	endfunction

	function automatic void add_limit(logic [CFG_W-1:0] limit);
		queue_op_t s;
		s.kind    = K_LIMIT;
		s.op      = OP_SEND;
		s.prio    = '0;
		s.payload = '0;
		s.len     = '0;
		s.cap     = '0;
		s.limit   = limit;
		ops_todo.push_back(s);
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// Driver: offer beats from ops_todo, predict each one at its handshake, and write
	// max_count only once every owed result has come back.
	always @(posedge clk or negedge arst_n) begin : feed
		logic      in_hold;
		logic      cfg_hold;
		logic      nv;
		logic      ncv;
		queue_op_t nxt;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			in_hold  = in_valid && !in_ready;
			cfg_hold = cfg_valid && !cfg_ready;
			nv       = in_hold;
			ncv      = cfg_hold;
			if (in_valid && in_ready) begin
				replies_due.push_back(shadow_apply(operation, send_priority, send_payload,
					send_length, receive_capacity));
				op_hits[operation]++;
				ops_taken++;
			end
			if (cfg_valid && cfg_ready) begin
				max_held_cfg = cfg_data;
				limit_writes++;
			end
			// hold the current beat until taken; only then look at the next step
			if (!in_hold && !cfg_hold) begin
				if (idle_left != 0) begin
					idle_left--;
				end else if (ops_todo.size() != 0) begin
					case (ops_todo[0].kind)
					K_OP: begin
						if (ops_todo.size() > TAIL_LEN && $urandom_range(0, 99) < idle_pct) begin
							idle_left = $urandom_range(0, 11);
						end else begin
							nxt = ops_todo.pop_front();
							operation        <= nxt.op;
							send_priority    <= nxt.prio;
							send_payload     <= nxt.payload;
							send_length      <= nxt.len;
							receive_capacity <= nxt.cap;
							nv = 1'b1;
						end
					end
					K_LIMIT: begin
						// pause the sender until the block has returned everything
						if (replies_due.size() == 0 && !in_valid) begin
							nxt = ops_todo.pop_front();
							cfg_data <= nxt.limit;
							ncv = 1'b1;
							case ($urandom_range(0, 3))
							0: idle_pct = 0;
							1: idle_pct = 10;
							2: idle_pct = 25;
							default: idle_pct = 45;
							endcase
						end
					end
					default: begin
						// ask the result side for its long hold, keep sending meanwhile
						nxt = ops_todo.pop_front();
						squeeze_asks++;
					end
					endcase
				end
			end
			in_valid  <= nv;
			cfg_valid <= ncv;
		end
	end

	// Monitor: check each result beat against the oldest owed result, and throttle
	// out_ready in bursts, with one long hold so the block backs up into its input.
	always @(posedge clk or negedge arst_n) begin : sink
		reply_t want;
		logic   nr;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				replies_seen++;
				if (replies_due.size() == 0) begin
					$error("result beat with no result owed: status %0d count %0d",
						status, queue_count);
					errors++;
				end else begin
					want = replies_due.pop_front();
					check_field("status", want.status, status);
					check_field("recv_payload", want.payload, recv_payload);
					check_field("recv_priority", want.prio, recv_priority);
					check_field("recv_length", want.len, recv_length);
					check_field("queue_count", want.count, queue_count);
					status_hits[want.status]++;
					if (int'(want.count) > deepest)
						deepest = int'(want.count);
				end
			end
			if (squeeze_seen != squeeze_asks) begin
				squeeze_seen = squeeze_asks;
				hold_left    = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				nr = 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				nr = 1'b0;
			end else if (ops_todo.size() > TAIL_LEN && $urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(0, 11);
				nr = 1'b0;
			end else begin
				nr = 1'b1;
			end
			out_ready <= nr;
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin : run
		queue_op_t        s;
		int               ph;
		int               n;
		int               roll;
		int               send_pm;
		logic [OP_W-1:0]  op;
		logic [PRIO_WIDTH-1:0] pr;
		logic [LEN_W-1:0] ln;
		logic [LEN_W-1:0] cp;

		// Directed part, max_count at its reset value.
		add_op(OP_RECV, 8'h00, 32'h0, 16'h0, 16'hFFFF);              // receive on empty
		add_op(OP_SEND, 8'hFF, 32'hFFFF_FFFF, 16'h0, 16'h0);         // zero length refused
		add_op(OP_SEND, 8'h00, 32'h0, 16'h1, 16'h0);                 // lowest priority
		add_op(OP_SEND, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);   // lands at the head
		add_op(OP_SEND, 8'h80, 32'hA5A5_A5A5, 16'hFFFF, 16'h0);
		add_op(OP_SEND, 8'h80, 32'h5A5A_5A5A, 16'h1234, 16'h0);      // tie: stays behind
		add_op(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF); // unused code
		add_op(OP_RECV, 8'h00, 32'h0, 16'h0, 16'h0);                 // capacity zero
		add_op(OP_RECV, 8'h00, 32'h0, 16'h0, 16'hFFFF);
		add_op(OP_RECV, 8'h00, 32'h0, 16'h0, 16'h0100);              // capacity clips length
		add_op(OP_RECV, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		add_op(OP_RECV, 8'h00, 32'h0, 16'h0, 16'h1);                 // empty again
		add_op(OP_SEND, 8'h01, 32'h0000_0001, 16'h0002, 16'h0);
		add_op(OP_SEND, 8'hFE, 32'h8000_0000, 16'h8000, 16'h0);
		add_op(OP_CLEAR, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);  // clear with content
		add_op(OP_CLEAR, 8'h00, 32'h0, 16'h0, 16'h0);                // clear when empty
		add_op(OP_RECV, 8'h00, 32'h0, 16'h0, 16'hFFFF);
		// Limit of one: second send full, zero length still reported as invalid.
		add_limit(5'd1);
		add_op(OP_SEND, 8'h10, 32'h1234_5678, 16'h0010, 16'h0);
		add_op(OP_SEND, 8'hFF, 32'h8765_4321, 16'h0020, 16'h0);
		add_op(OP_SEND, 8'hFF, 32'h0, 16'h0, 16'h0);
		add_op(OP_RECV, 8'h00, 32'h0, 16'h0, 16'h0008);
		// Limit of zero: every send refused as full.
		add_limit(5'd0);
		add_op(OP_SEND, 8'h40, 32'hDEAD_BEEF, 16'h0040, 16'h0);
		add_op(OP_RECV, 8'h00, 32'h0, 16'h0, 16'hFFFF);

		// Random phases: one max_count each, send pressure rerolled every 30 beats.
		// Priorities lean on a few values so ties are common; lengths and capacities
		// hit zero and all ones often.
		for (ph = 0; ph < PHASES; ph++) begin
			add_limit(phase_limits[ph]);
			if (ph == SQUEEZE_PHASE) begin
				s.kind    = K_SQUEEZE;
				s.op      = OP_SEND;
				s.prio    = '0;
				s.payload = '0;
				s.len     = '0;
				s.cap     = '0;
				s.limit   = '0;
				ops_todo.push_back(s);
			end
			send_pm = 550;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 30 == 0) begin
					case ($urandom_range(0, 2))
					0: send_pm = 350;
					1: send_pm = 550;
					default: send_pm = 800;
					endcase
					if (ph == SQUEEZE_PHASE && n == 0)
						send_pm = 850;
				end
				roll = $urandom_range(0, 999);
				if (roll < send_pm)
					op = OP_SEND;
				else if (roll < 985)
					op = OP_RECV;
				else if (roll < 997)
					op = OP_CLEAR;
				else
					op = OP_UNUSED;
				case ($urandom_range(0, 3))
				0: pr = PRIO_WIDTH'($urandom_range(0, 3));
				1: pr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				default: pr = PRIO_WIDTH'($urandom);
				endcase
				case ($urandom_range(0, 15))
				0: ln = '0;
				1: ln = 16'hFFFF;
				2: ln = 16'h1;
				default: ln = LEN_W'($urandom);
				endcase
				case ($urandom_range(0, 7))
				0: cp = '0;
				1: cp = 16'hFFFF;
				default: cp = LEN_W'($urandom);
				endcase
				add_op(op, pr, $urandom, ln, cp);
			end
		end

		// Release reset away from the rising edge.
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every step is offered and every owed result is back, then linger.
		while (ops_todo.size() != 0 || in_valid || cfg_valid || replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d beats (send %0d, receive %0d, clear %0d, unused %0d), %0d results,",
			ops_taken, op_hits[OP_SEND], op_hits[OP_RECV], op_hits[OP_CLEAR], op_hits[OP_UNUSED],
			replies_seen);
		$display("summary: %0d max_count writes; ok %0d, full %0d, empty %0d, invalid %0d; depth %0d",
			limit_writes, status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
			status_hits[ST_INVALID], deepest);
		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/spmq_pkg.sv
design/spmq_ram.sv
design/spmq_cmp.sv
design/stable_priority_message_queue_unit.sv
tb/sv/tb.sv
